@@ rtl/mft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mft_pkg;
    localparam int IFACES_DEF = 4;
    localparam int GROUPS_DEF = 16;
    localparam logic [2:0] MODE_ADD_IF   = 3'd0;
    localparam logic [2:0] MODE_ADD_GRP  = 3'd1;
    localparam logic [2:0] MODE_DEL_GRP  = 3'd2;
    localparam logic [2:0] MODE_FORWARD  = 3'd3;
    localparam logic [2:0] MODE_LOOKUP   = 3'd4;
    localparam logic [2:0] MODE_QUERY    = 3'd5;
    localparam logic [2:0] MODE_RSVD6    = 3'd6;
    localparam logic [2:0] MODE_RSVD7    = 3'd7;
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_addr;
        logic [7:0]  out_ttl;
        logic        receivers_known;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/mft_entry_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mft_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [63:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [63:0]   rdata
);
    logic [63:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/multicast_forwarding_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Multicast (source, group) forwarding table. Interface records sit in flip-flops;
// (group, source) entries sit in one synchronous RAM, with one packed entry count
// per interface. One word is taken at a time, and the next once the last result of
// the previous word has been accepted. Add interface and lookup go from the find
// state straight to the output state. Add group scans the interface's entries one
// RAM read per cycle; delete group scans the same way and then moves each later
// entry up one slot, with a read and then a write per entry. Forward and query scan
// every interface; new reads are held off while an output word waits to be accepted.
// Forward gives one word per matching entry with tlast on the final one.
// No clearing pass: counts reset to zero.
module multicast_forwarding_table #(
    parameter int IFACES = mft_pkg::IFACES_DEF,
    parameter int GROUPS = mft_pkg::GROUPS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // iface_addr, neighbor_addr, group_addr, source_addr, packet_ttl
    input  wire logic [135:0] s_tdata,
    // mode
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, out_addr, out_ttl, receivers_known, pad
    output logic [47:0]       m_tdata,
    output logic              m_tlast
);
    import mft_pkg::*;

    localparam int IW = (IFACES > 1) ? $clog2(IFACES) : 1;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW = $clog2(GROUPS + 1);
    localparam int AW = IW + GW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  mode_reg;
    logic [31:0] ifa_reg, nbr_reg, grp_reg, src_reg;
    logic [7:0]  ttl_reg;
    logic [IFACES-1:0] ivalid_reg;
    logic [31:0] iaddr_reg [IFACES];
    logic [31:0] inbr_reg [IFACES];
    logic [CW-1:0] cnt_reg [IFACES];
    logic [IW-1:0] if_reg;
    logic [CW-1:0] k_reg;
    logic        rd_pend_reg;
    logic [IW-1:0] rif_reg;
    logic [CW-1:0] rk_reg;
    logic        rlast_reg;
    logic        found_reg;
    logic        hit_reg;
    logic        done_reg;
    result_t     res_reg;
    logic        have_pend_reg;
    result_t     pend_reg;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;

    mft_entry_ram #(.DEPTH(IFACES * (2 ** GW)), .AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic fnd;
    logic [IW-1:0] fidx;
    logic free_any;
    logic [IW-1:0] fridx;
    always_comb begin
        fnd = 1'b0;
        fidx = '0;
        free_any = 1'b0;
        fridx = '0;
        for (int i = IFACES - 1; i >= 0; i--) begin
            if (ivalid_reg[i] && iaddr_reg[i] == ifa_reg) begin
                fnd = 1'b1;
                fidx = IW'(i);
            end
            if (!ivalid_reg[i]) begin
                free_any = 1'b1;
                fridx = IW'(i);
            end
        end
    end

    wire logic out_busy = m_tvalid && !m_tready;
    wire logic rd_match = rd_pend_reg && rdata[63:32] == grp_reg && rdata[31:0] == src_reg;
    wire logic rd_gmatch = rd_pend_reg && rdata[63:32] == grp_reg;

    function automatic result_t mk(input logic [2:0] st, input logic [31:0] a,
                                   input logic [7:0] t, input logic r, input logic l);
        result_t x;
        x.status = st;
        x.out_addr = a;
        x.out_ttl = t;
        x.receivers_known = r;
        x.last = l;
        return x;
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;
    assign m_tvalid = have_pend_reg;
    assign m_tdata = {4'b0000, pend_reg.receivers_known, pend_reg.out_ttl,
                      pend_reg.out_addr, pend_reg.status};
    assign m_tlast = pend_reg.last;

    // scan issue: next (iface, k) with count check
    logic issue;
    always_comb begin
        issue = (state_reg == S_SCAN) && !done_reg && !out_busy
                && (k_reg < cnt_reg[if_reg]) && ivalid_reg[if_reg];
        raddr = {if_reg, k_reg[GW-1:0]};
        we = 1'b0;
        waddr = {if_reg, k_reg[GW-1:0]};
        wdata = rdata;
        if (state_reg == S_SHIFT && rd_pend_reg) begin
            we = 1'b1;
            waddr = {rif_reg, GW'(rk_reg - CW'(1))};
        end else if (state_reg == S_OUT && mode_reg == MODE_ADD_GRP
                     && res_reg.status == ST_DONE) begin
            we = 1'b1;
            waddr = {if_reg, GW'(cnt_reg[if_reg])};
            wdata = {grp_reg, src_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ivalid_reg <= '0;
            have_pend_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < IFACES; i++) cnt_reg[i] <= '0;
        end else begin
            if (have_pend_reg && m_tready) have_pend_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        mode_reg <= s_tuser;
                        ifa_reg <= s_tdata[31:0];
                        nbr_reg <= s_tdata[63:32];
                        grp_reg <= s_tdata[95:64];
                        src_reg <= s_tdata[127:96];
                        ttl_reg <= s_tdata[135:128];
                        if (s_tuser <= MODE_QUERY) state_reg <= S_FIND;
                    end
                end
                S_FIND: begin
                    found_reg <= 1'b0;
                    hit_reg <= 1'b0;
                    done_reg <= 1'b0;
                    k_reg <= '0;
                    case (mode_reg)
                        MODE_ADD_IF: begin
                            if (fnd) res_reg <= mk(ST_DUPLICATE, '0, '0, 1'b0, 1'b1);
                            else if (!free_any) res_reg <= mk(ST_FULL, '0, '0, 1'b0, 1'b1);
                            else begin
                                res_reg <= mk(ST_DONE, '0, '0, 1'b0, 1'b1);
                                ivalid_reg[fridx] <= 1'b1;
                                iaddr_reg[fridx] <= ifa_reg;
                                inbr_reg[fridx] <= nbr_reg;
                                cnt_reg[fridx] <= '0;
                            end
                            state_reg <= S_OUT;
                        end
                        MODE_LOOKUP: begin
                            res_reg <= fnd ? mk(ST_DONE, inbr_reg[fidx], '0, 1'b0, 1'b1)
                                           : mk(ST_UNKNOWN, '0, '0, 1'b0, 1'b1);
                            state_reg <= S_OUT;
                        end
                        MODE_ADD_GRP, MODE_DEL_GRP: begin
                            if_reg <= fidx;
                            if (!fnd) begin
                                res_reg <= mk(ST_UNKNOWN, '0, '0, 1'b0, 1'b1);
                                state_reg <= S_OUT;
                            end else state_reg <= S_SCAN;
                        end
                        default: begin
                            if_reg <= '0;
                            state_reg <= S_SCAN;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (issue) begin
                        rd_pend_reg <= 1'b1;
                        rif_reg <= if_reg;
                        rk_reg <= k_reg;
                        k_reg <= k_reg + CW'(1);
                    end else if (!rd_pend_reg && !out_busy && !done_reg) begin
                        // this interface exhausted
                        if (mode_reg == MODE_ADD_GRP || mode_reg == MODE_DEL_GRP
                            || if_reg == IW'(IFACES - 1)) begin
                            done_reg <= 1'b1;
                        end else begin
                            if_reg <= if_reg + IW'(1);
                            k_reg <= '0;
                        end
                    end
                    if (rd_pend_reg) begin
                        case (mode_reg)
                            MODE_ADD_GRP: if (rd_gmatch) begin
                                done_reg <= 1'b1; hit_reg <= 1'b1;
                            end
                            MODE_DEL_GRP: if (rd_match) begin
                                done_reg <= 1'b1; hit_reg <= 1'b1;
                                k_reg <= rk_reg + CW'(1);
                            end
                            MODE_QUERY: if (rd_match) found_reg <= 1'b1;
                            default: if (rd_match) begin
                                if (hit_reg) begin
                                    have_pend_reg <= 1'b1;
                                    pend_reg <= res_reg;
                                end
                                hit_reg <= 1'b1;
                                res_reg <= mk(ST_DONE, inbr_reg[rif_reg], ttl_reg - 8'd1,
                                              1'b0, 1'b0);
                            end
                        endcase
                    end
                    if (done_reg && !rd_pend_reg) begin
                        case (mode_reg)
                            MODE_ADD_GRP: begin
                                if (hit_reg) res_reg <= mk(ST_DUPLICATE, '0, '0, 1'b0, 1'b1);
                                else if (cnt_reg[if_reg] == CW'(GROUPS))
                                    res_reg <= mk(ST_FULL, '0, '0, 1'b0, 1'b1);
                                else res_reg <= mk(ST_DONE, '0, '0, 1'b0, 1'b1);
                                state_reg <= S_OUT;
                            end
                            MODE_DEL_GRP: begin
                                if (hit_reg) begin
                                    res_reg <= mk(ST_DONE, '0, '0, 1'b0, 1'b1);
                                    state_reg <= S_SHIFT;
                                end else begin
                                    res_reg <= mk(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
                                    state_reg <= S_OUT;
                                end
                            end
                            MODE_QUERY: begin
                                res_reg <= mk(ST_DONE, '0, '0, found_reg, 1'b1);
                                state_reg <= S_OUT;
                            end
                            default: begin
                                if (hit_reg) begin
                                    res_reg.last <= 1'b1;
                                    state_reg <= S_OUT;
                                end else state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // k_reg points past the removed slot; copy k to k-1
                    if (!rd_pend_reg) begin
                        if (k_reg < cnt_reg[if_reg] && k_reg != '0) begin
                            rd_pend_reg <= 1'b1;
                            rif_reg <= if_reg;
                            rk_reg <= k_reg;
                            k_reg <= k_reg + CW'(1);
                        end else begin
                            cnt_reg[if_reg] <= cnt_reg[if_reg] - CW'(1);
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!out_busy) begin
                        have_pend_reg <= 1'b1;
                        pend_reg <= res_reg;
                        if (mode_reg == MODE_ADD_GRP && res_reg.status == ST_DONE)
                            cnt_reg[if_reg] <= cnt_reg[if_reg] + CW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/mft_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mft_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [47:0]  m_tdata,
    input wire logic         m_tlast
);
    import mft_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_NOT_FOUND)
        else $error("bad status");
    a_ttl_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[2:0] == ST_DONE && m_tdata[43] == 1'b0)
        else $error("non-final word is not a forward word");
    a_no_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule
bind multicast_forwarding_table mft_checker u_mft_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

@@ test/multicast_forwarding_table_chk.sv @@
`timescale 1ns / 1ps
module multicast_forwarding_table_chk #(
    parameter int IFACES = mft_pkg::IFACES_DEF,
    parameter int GROUPS = mft_pkg::GROUPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);
    import mft_pkg::*;

    localparam int SLOTS = IFACES * GROUPS;

    logic        if_used [IFACES];
    logic [31:0] if_addr [IFACES];
    logic [31:0] if_nbr  [IFACES];
    logic        ent_used[SLOTS];
    logic [31:0] ent_grp [SLOTS];
    logic [31:0] ent_src [SLOTS];

    result_t expected_words[$];

    assign pending = expected_words.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic expect_word(input result_t r);
        expected_words = {expected_words, r};
    endtask

    function automatic int find_if(input logic [31:0] a);
        for (int i = 0; i < IFACES; i++)
            if (if_used[i] && if_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic result_t word(input logic [2:0] st, input logic [31:0] ad,
                                     input logic [7:0] tt, input logic rk);
        result_t r;
        r.status = st; r.out_addr = ad; r.out_ttl = tt;
        r.receivers_known = rk; r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_table(input logic [2:0] mode, input logic [135:0] d);
        logic [31:0] ifa, nbr, grp, src;
        logic [7:0]  ttl;
        int i, b, n;
        logic hit, dup, done;
        ifa = d[31:0]; nbr = d[63:32]; grp = d[95:64]; src = d[127:96]; ttl = d[135:128];
        i = find_if(ifa);
        case (mode)
            MODE_ADD_IF: begin
                done = 1'b0;
                if (i >= 0) expect_word(word(ST_DUPLICATE, '0, '0, 1'b0));
                else begin
                    for (int j = 0; j < IFACES && !done; j++)
                        if (!if_used[j]) begin
                            if_used[j] = 1'b1; if_addr[j] = ifa; if_nbr[j] = nbr;
                            done = 1'b1;
                        end
                    expect_word(word(done ? ST_DONE : ST_FULL, '0, '0, 1'b0));
                end
            end
            MODE_ADD_GRP: begin
                if (i < 0) expect_word(word(ST_UNKNOWN, '0, '0, 1'b0));
                else begin
                    b = i * GROUPS; dup = 1'b0; done = 1'b0;
                    for (int k = 0; k < GROUPS; k++)
                        if (ent_used[b+k] && ent_grp[b+k] == grp) dup = 1'b1;
                    if (dup) expect_word(word(ST_DUPLICATE, '0, '0, 1'b0));
                    else begin
                        for (int k = 0; k < GROUPS && !done; k++)
                            if (!ent_used[b+k]) begin
                                ent_used[b+k] = 1'b1; ent_grp[b+k] = grp; ent_src[b+k] = src;
                                done = 1'b1;
                            end
                        expect_word(word(done ? ST_DONE : ST_FULL, '0, '0, 1'b0));
                    end
                end
            end
            MODE_DEL_GRP: begin
                if (i < 0) expect_word(word(ST_UNKNOWN, '0, '0, 1'b0));
                else begin
                    b = i * GROUPS; done = 1'b0;
                    for (int k = 0; k < GROUPS && !done; k++)
                        if (ent_used[b+k] && ent_grp[b+k] == grp && ent_src[b+k] == src) begin
                            for (int m = k; m + 1 < GROUPS; m++) begin
                                ent_used[b+m] = ent_used[b+m+1];
                                ent_grp[b+m]  = ent_grp[b+m+1];
                                ent_src[b+m]  = ent_src[b+m+1];
                            end
                            ent_used[b+GROUPS-1] = 1'b0;
                            done = 1'b1;
                        end
                    expect_word(word(done ? ST_DONE : ST_NOT_FOUND, '0, '0, 1'b0));
                end
            end
            MODE_FORWARD: begin
                n = 0;
                for (int j = 0; j < IFACES; j++)
                    for (int k = 0; k < GROUPS; k++)
                        if (if_used[j] && ent_used[j*GROUPS+k] && ent_grp[j*GROUPS+k] == grp
                            && ent_src[j*GROUPS+k] == src) begin
                            result_t r;
                            r = word(ST_DONE, if_nbr[j], ttl - 8'd1, 1'b0);
                            r.last = 1'b0;
                            expect_word(r);
                            n++;
                        end
                if (n > 0) expected_words[$].last = 1'b1;
            end
            MODE_LOOKUP:
                expect_word(i < 0 ? word(ST_UNKNOWN, '0, '0, 1'b0)
                                  : word(ST_DONE, if_nbr[i], '0, 1'b0));
            MODE_QUERY: begin
                hit = 1'b0;
                for (int j = 0; j < IFACES; j++)
                    for (int k = 0; k < GROUPS; k++)
                        if (if_used[j] && ent_used[j*GROUPS+k] && ent_grp[j*GROUPS+k] == grp
                            && ent_src[j*GROUPS+k] == src) hit = 1'b1;
                expect_word(word(ST_DONE, '0, '0, hit));
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors = 0;
            expected_words.delete();
            for (int i = 0; i < IFACES; i++) if_used[i] = 1'b0;
            for (int i = 0; i < SLOTS; i++) ent_used[i] = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", 64'(m_tdata), 64'd0);
                end else begin
                    result_t w;
                    w = expected_words.pop_front();
                    if (m_tdata[2:0] !== w.status)
                        report("status", 64'(m_tdata[2:0]), 64'(w.status));
                    if (m_tdata[34:3] !== w.out_addr)
                        report("out_addr", 64'(m_tdata[34:3]), 64'(w.out_addr));
                    if (m_tdata[42:35] !== w.out_ttl)
                        report("out_ttl", 64'(m_tdata[42:35]), 64'(w.out_ttl));
                    if (m_tdata[43] !== w.receivers_known)
                        report("receivers_known", 64'(m_tdata[43]), 64'(w.receivers_known));
                    if (m_tdata[47:44] !== 4'd0) report("pad", 64'(m_tdata[47:44]), 64'd0);
                    if (m_tlast !== w.last) report("tlast", 64'(m_tlast), 64'(w.last));
                end
            end
            if (s_tvalid && s_tready) predict_table(s_tuser, s_tdata);
        end
    end
endmodule

@@ test/multicast_forwarding_table_tb.sv @@
`timescale 1ns / 1ps
module multicast_forwarding_table_tb;
    import mft_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           cycles = 0;
    bit           hold_off = 0;

    logic [31:0] if_pool[4];
    logic [31:0] grp_pool[6];
    logic [31:0] src_pool[4];

    multicast_forwarding_table dut (.*);

    multicast_forwarding_table_chk chk (.*);

    initial forever #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic [2:0] mode, input logic [31:0] ifa, input logic [31:0] nbr,
                        input logic [31:0] grp, input logic [31:0] src, input logic [7:0] ttl);
        int g;
        g = hold_off ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {ttl, src, grp, nbr, ifa};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random();
        int r;
        logic [2:0] mode;
        logic [31:0] ifa, grp, src;
        r = $urandom_range(0, 99);
        if (r < 8) mode = MODE_ADD_IF;
        else if (r < 35) mode = MODE_ADD_GRP;
        else if (r < 50) mode = MODE_DEL_GRP;
        else if (r < 75) mode = MODE_FORWARD;
        else if (r < 85) mode = MODE_LOOKUP;
        else if (r < 95) mode = MODE_QUERY;
        else mode = ($urandom_range(0, 1) == 0) ? MODE_RSVD6 : MODE_RSVD7;
        ifa = ($urandom_range(0, 9) == 0) ? $urandom() : if_pool[$urandom_range(0, 3)];
        grp = ($urandom_range(0, 9) == 0) ? $urandom() : grp_pool[$urandom_range(0, 5)];
        src = ($urandom_range(0, 9) == 0) ? $urandom() : src_pool[$urandom_range(0, 3)];
        send(mode, ifa, $urandom(), grp, src, 8'($urandom()));
    endtask

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else if ($urandom_range(0, 99) < 60) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 99) < 10);
    end

    initial begin
        int n;
        for (int i = 0; i < 4; i++) if_pool[i] = $urandom();
        for (int i = 0; i < 6; i++) grp_pool[i] = $urandom();
        for (int i = 0; i < 4; i++) src_pool[i] = $urandom();
        if_pool[0] = 32'h0; if_pool[1] = 32'hFFFF_FFFF;
        grp_pool[0] = 32'h0; grp_pool[1] = 32'hFFFF_FFFF;
        src_pool[0] = 32'hFFFF_FFFF;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        send(MODE_LOOKUP, if_pool[0], 0, 0, 0, 0);
        send(MODE_ADD_GRP, if_pool[0], 0, grp_pool[0], src_pool[0], 0);
        send(MODE_DEL_GRP, if_pool[0], 0, grp_pool[0], src_pool[0], 0);
        for (int i = 0; i < 4; i++)
            send(MODE_ADD_IF, if_pool[i], (i == 0) ? 32'hFFFF_FFFF : $urandom(), 0, 0, 0);
        send(MODE_ADD_IF, if_pool[1], 0, 0, 0, 0);
        send(MODE_ADD_IF, 32'h1234_5678, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send(MODE_ADD_GRP, if_pool[i], 0, grp_pool[1], src_pool[0], 0);
        send(MODE_ADD_GRP, if_pool[0], 0, grp_pool[1], src_pool[1], 0);
        send(MODE_FORWARD, 0, 0, grp_pool[1], src_pool[0], 8'h00);
        send(MODE_FORWARD, 0, 0, grp_pool[1], src_pool[0], 8'hFF);
        send(MODE_FORWARD, 0, 0, grp_pool[2], src_pool[0], 8'h01);
        send(MODE_QUERY, 0, 0, grp_pool[1], src_pool[0], 0);
        send(MODE_QUERY, 0, 0, grp_pool[1], src_pool[2], 0);
        send(MODE_LOOKUP, if_pool[0], 0, 0, 0, 0);
        send(MODE_DEL_GRP, if_pool[1], 0, grp_pool[1], src_pool[1], 0);
        send(MODE_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send(MODE_RSVD7, 0, 0, 0, 0, 0);
        // fill one interface to capacity, then overflow
        for (int k = 0; k < 17; k++)
            send(MODE_ADD_GRP, if_pool[2], 0, 32'hE000_0000 + k, src_pool[0], 0);
        send(MODE_DEL_GRP, if_pool[2], 0, 32'hE000_0003, src_pool[0], 0);

        // long receiver hold-off while input keeps coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            begin
                for (n = 0; n < 20; n++) send_random();
            end
        join

        for (n = 0; n < 170; n++) send_random();
        s_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ multicast_forwarding_table.f @@
rtl/mft_pkg.sv
rtl/mft_entry_ram.sv
rtl/multicast_forwarding_table.sv
rtl/mft_checker.sv
test/multicast_forwarding_table_chk.sv
test/multicast_forwarding_table_tb.sv
